[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hw/rtl/pehip_pkg.sv]
// ----------------------------------------------------------------------------
// pehip_pkg
// types and constants of the executable header identity parser
// ----------------------------------------------------------------------------
package pehip_pkg;

   localparam int unsigned CountWidth = 21;

   localparam logic [CountWidth-1:0] COUNT_MAX        = '1;
   localparam logic [CountWidth-1:0] OFFSET_FIELD_POS = 21'h3C;
   localparam logic [CountWidth-1:0] MIN_HEADER_POS   = 21'd64;
   localparam logic [CountWidth-1:0] MZ_POS_M         = 21'd0;
   localparam logic [CountWidth-1:0] MZ_POS_Z         = 21'd1;

   localparam logic [31:0] MIN_HEADER_OFFSET     = 32'd64;
   localparam logic [31:0] MAX_HEADER_OFFSET     = 32'd1048576;
   localparam logic [33:0] REQUIRED_AFTER_HEADER = 34'd44;
   localparam logic [33:0] SIG_AND_FILE_HEADER   = 34'd24;
   localparam logic [15:0] MIN_OPTIONAL_SIZE     = 16'd20;
   localparam int unsigned DLL_BIT               = 13;

   localparam logic [7:0] CHAR_M = 8'h4D;
   localparam logic [7:0] CHAR_Z = 8'h5A;
   localparam logic [7:0] CHAR_P = 8'h50;
   localparam logic [7:0] CHAR_E = 8'h45;

   // byte positions relative to the header offset
   localparam logic [5:0] REL_SIG_P    = 6'd0;
   localparam logic [5:0] REL_SIG_E    = 6'd1;
   localparam logic [5:0] REL_SIG_Z0   = 6'd2;
   localparam logic [5:0] REL_SIG_Z1   = 6'd3;
   localparam logic [5:0] REL_MACH_LO  = 6'd4;
   localparam logic [5:0] REL_MACH_HI  = 6'd5;
   localparam logic [5:0] REL_OPT_LO   = 6'd20;
   localparam logic [5:0] REL_OPT_HI   = 6'd21;
   localparam logic [5:0] REL_CHAR_LO  = 6'd22;
   localparam logic [5:0] REL_CHAR_HI  = 6'd23;
   localparam logic [5:0] REL_MAGIC_LO = 6'd24;
   localparam logic [5:0] REL_MAGIC_HI = 6'd25;
   localparam logic [5:0] REL_ENTRY_0  = 6'd40;
   localparam logic [5:0] REL_ENTRY_1  = 6'd41;
   localparam logic [5:0] REL_ENTRY_2  = 6'd42;
   localparam logic [5:0] REL_ENTRY_3  = 6'd43;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic        valid_res;
      logic [15:0] machine;
      logic [15:0] optional_magic;
      logic [31:0] entry_point;
      logic        is_dll;
   } rsp_payload_type;

endpackage

[hw/rtl/pehip_core.sv]
// ----------------------------------------------------------------------------
// pehip_core
// per-image parse state, byte capture and end-of-image verdict
// ----------------------------------------------------------------------------
module pehip_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  pehip_pkg::req_payload_type item,
   output pehip_pkg::rsp_payload_type result
);
   import pehip_pkg::*;

   logic [CountWidth-1:0] count_ff, count_in;
   logic [31:0]           offset_ff, offset_in;
   logic                  failed_ff, failed_in;
   logic [15:0]           opt_size_ff, opt_size_in;
   logic [15:0]           machine_ff, machine_in;
   logic [15:0]           chars_ff, chars_in;
   logic [15:0]           magic_ff, magic_in;
   logic [31:0]           entry_ff, entry_in;

   logic [32:0] rel_diff;
   logic [5:0]  rel_lo;
   logic        rel_near;
   logic [33:0] size_ext;
   logic [33:0] offset_ext;
   logic        ok;

   always_comb begin
      count_in    = count_ff;
      offset_in   = offset_ff;
      failed_in   = failed_ff;
      opt_size_in = opt_size_ff;
      machine_in  = machine_ff;
      chars_in    = chars_ff;
      magic_in    = magic_ff;
      entry_in    = entry_ff;

      rel_diff = {12'd0, count_ff} - {1'b0, offset_ff};
      rel_lo   = rel_diff[5:0];
      rel_near = !rel_diff[32] && (rel_diff[31:6] == '0);

      if (take && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + 1'b1;
         if ((count_ff == MZ_POS_M) && (item.data_byte != CHAR_M)) begin
            failed_in = 1'b1;
         end
         if ((count_ff == MZ_POS_Z) && (item.data_byte != CHAR_Z)) begin
            failed_in = 1'b1;
         end
         if (count_ff[CountWidth-1:2] == OFFSET_FIELD_POS[CountWidth-1:2]) begin
            case (count_ff[1:0])
               2'd0:    offset_in[7:0]   = item.data_byte;
               2'd1:    offset_in[15:8]  = item.data_byte;
               2'd2:    offset_in[23:16] = item.data_byte;
               default: offset_in[31:24] = item.data_byte;
            endcase
            if ((count_ff[1:0] == 2'd3) &&
                ((offset_in < MIN_HEADER_OFFSET) || (offset_in > MAX_HEADER_OFFSET))) begin
               failed_in = 1'b1;
            end
         end else if (!failed_ff && (count_ff >= MIN_HEADER_POS) && rel_near) begin
            case (rel_lo) inside
               REL_SIG_P: begin
                  if (item.data_byte != CHAR_P) failed_in = 1'b1;
               end
               REL_SIG_E: begin
                  if (item.data_byte != CHAR_E) failed_in = 1'b1;
               end
               REL_SIG_Z0, REL_SIG_Z1: begin
                  if (item.data_byte != 8'd0) failed_in = 1'b1;
               end
               REL_MACH_LO:  machine_in[7:0]   = item.data_byte;
               REL_MACH_HI:  machine_in[15:8]  = item.data_byte;
               REL_OPT_LO:   opt_size_in[7:0]  = item.data_byte;
               REL_OPT_HI:   opt_size_in[15:8] = item.data_byte;
               REL_CHAR_LO:  chars_in[7:0]     = item.data_byte;
               REL_CHAR_HI:  chars_in[15:8]    = item.data_byte;
               REL_MAGIC_LO: magic_in[7:0]     = item.data_byte;
               REL_MAGIC_HI: magic_in[15:8]    = item.data_byte;
               REL_ENTRY_0:  entry_in[7:0]     = item.data_byte;
               REL_ENTRY_1:  entry_in[15:8]    = item.data_byte;
               REL_ENTRY_2:  entry_in[23:16]   = item.data_byte;
               REL_ENTRY_3:  entry_in[31:24]   = item.data_byte;
               default: ;
            endcase
         end
      end

      size_ext   = {13'd0, count_in};
      offset_ext = {2'd0, offset_in};
      ok = !failed_in
         && (count_in >= MIN_HEADER_POS)
         && (size_ext >= offset_ext + REQUIRED_AFTER_HEADER)
         && (opt_size_in >= MIN_OPTIONAL_SIZE)
         && (size_ext >= offset_ext + SIG_AND_FILE_HEADER + {18'd0, opt_size_in});

      result.valid_res      = ok;
      result.machine        = ok ? machine_in : 16'd0;
      result.optional_magic = ok ? magic_in : 16'd0;
      result.entry_point    = ok ? entry_in : 32'd0;
      result.is_dll         = ok && chars_in[DLL_BIT];

      // rearm for the next image
      if (take && item.last_byte) begin
         count_in    = '0;
         offset_in   = '0;
         failed_in   = 1'b0;
         opt_size_in = '0;
         machine_in  = '0;
         chars_in    = '0;
         magic_in    = '0;
         entry_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         offset_ff   <= '0;
         failed_ff   <= 1'b0;
         opt_size_ff <= '0;
         machine_ff  <= '0;
         chars_ff    <= '0;
         magic_ff    <= '0;
         entry_ff    <= '0;
      end else begin
         count_ff    <= count_in;
         offset_ff   <= offset_in;
         failed_ff   <= failed_in;
         opt_size_ff <= opt_size_in;
         machine_ff  <= machine_in;
         chars_ff    <= chars_in;
         magic_ff    <= magic_in;
         entry_ff    <= entry_in;
      end
   end

endmodule

[hw/rtl/pe_header_identity_parser_top.sv]
// ----------------------------------------------------------------------------
// pe_header_identity_parser_top
// streams an executable image one byte per transfer and reports its identity
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one image byte per transfer, last_byte marks the end
//   rsp channel carries one verdict per image: valid_res plus machine,
//   optional magic, entry point and dll flag (all zero when invalid)
//   throughput is one byte per cycle while no verdict is held by rsp_stall:
//   a byte is registered, then parsed into the header state by a position
//   compare and a capture; the verdict passes from the input register through
//   the rsp register to rsp_valid; a byte that produces no result never waits
//   on the rsp side; the last byte waits in the input register only while an
//   earlier verdict is held by rsp_stall, and req_stall rises in that case
//   reset clears the byte count and all captured header fields, and drops
//   any byte or verdict in flight
// ----------------------------------------------------------------------------
module pe_header_identity_parser_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  pehip_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output pehip_pkg::rsp_payload_type rsp_payload
);
   import pehip_pkg::*;

   logic            in_vld_ff, in_vld_in;
   req_payload_type in_data_ff, in_data_in;
   logic            rsp_vld_ff, rsp_vld_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            out_free;
   logic            parse_move;
   rsp_payload_type core_result;

   assign out_free   = !rsp_vld_ff || !rsp_stall;
   assign parse_move = in_vld_ff && (!in_data_ff.last_byte || out_free);
   assign req_stall  = in_vld_ff && !parse_move;

   pehip_core u_core (
      .clock  (clock),
      .reset  (reset),
      .take   (parse_move),
      .item   (in_data_ff),
      .result (core_result)
   );

   always_comb begin
      in_vld_in   = in_vld_ff;
      in_data_in  = in_data_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (!req_stall) begin
         in_vld_in  = req_valid;
         in_data_in = req_payload;
      end
      if (parse_move && in_data_ff.last_byte) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = core_result;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

[hw/rtl/pehip_checker.sv]
// ----------------------------------------------------------------------------
// pehip_checker
// port-level assertions for the header identity parser
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pehip_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input pehip_pkg::req_payload_type req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input pehip_pkg::rsp_payload_type rsp_payload
);
   import pehip_pkg::*;

   logic take_last;
   logic rsp_held;
   logic fields_zero;

   assign take_last   = req_valid && !req_stall && req_payload.last_byte;
   assign rsp_held    = rsp_valid && rsp_stall;
   assign fields_zero = (rsp_payload.machine == 16'd0) && (rsp_payload.optional_magic == 16'd0)
                        && (rsp_payload.entry_point == 32'd0) && !rsp_payload.is_dll;

   // held verdict stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_payload))

   // failed image reports zero fields
   `ASSERT_IMPLIES(a_invalid_zero, clock, reset, rsp_valid && !rsp_payload.valid_res, fields_zero)

   // a fresh verdict follows a last-byte transfer through the input and rsp registers
   `ASSERT_IMPLIES(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(take_last, 2))

   // ordinary bytes never wait while no verdict is held
   `ASSERT_IMPLIES(a_no_idle_stall, clock, reset, !rsp_valid && !$past(reset), !req_stall)

endmodule

bind pe_header_identity_parser_top pehip_checker u_pehip_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

[bench/pehip_bench_pkg.sv]
// ----------------------------------------------------------------------------
// pehip_bench_pkg
// verdict predictor and scoreboard for the executable header identity parser
// ----------------------------------------------------------------------------
// tracks the parse state byte by byte as bytes are accepted, queues one
// expected verdict per image and compares each returned verdict field by field
// ----------------------------------------------------------------------------
package pehip_bench_pkg;

   import pehip_pkg::*;

   class pe_identity_scoreboard;

      logic [CountWidth-1:0] byte_count;
      logic [31:0]           header_offset;
      bit                    failed;
      logic [15:0]           optional_size;
      logic [15:0]           machine_word;
      logic [15:0]           characteristics_word;
      logic [15:0]           magic_word;
      logic [31:0]           entry_word;

      rsp_payload_type verdicts[$];
      int unsigned     mismatches;
      int unsigned     checked;
      int unsigned     images;
      int unsigned     valid_images;

      function new();
         rearm();
         mismatches   = 0;
         checked      = 0;
         images       = 0;
         valid_images = 0;
      endfunction

      function void rearm();
         byte_count           = '0;
         header_offset        = '0;
         failed               = 1'b0;
         optional_size        = '0;
         machine_word         = '0;
         characteristics_word = '0;
         magic_word           = '0;
         entry_word           = '0;
      endfunction

      function void parse_byte(logic [CountWidth-1:0] idx, logic [7:0] b);
         int unsigned lane;
         logic [31:0] rel;
         if (idx == MZ_POS_M && b != CHAR_M) failed = 1'b1;
         if (idx == MZ_POS_Z && b != CHAR_Z) failed = 1'b1;
         if (idx >= OFFSET_FIELD_POS && idx < OFFSET_FIELD_POS + 4) begin
            lane = idx - OFFSET_FIELD_POS;
            header_offset[8*lane +: 8] = b;
            if (idx == OFFSET_FIELD_POS + 3 &&
                (header_offset < MIN_HEADER_OFFSET || header_offset > MAX_HEADER_OFFSET))
               failed = 1'b1;
            return;
         end
         if (failed || idx < MIN_HEADER_POS || 32'(idx) < header_offset) return;
         rel = 32'(idx) - header_offset;
         case (rel)
            REL_SIG_P:              if (b != CHAR_P) failed = 1'b1;
            REL_SIG_E:              if (b != CHAR_E) failed = 1'b1;
            REL_SIG_Z0, REL_SIG_Z1: if (b != 8'h00) failed = 1'b1;
            REL_MACH_LO:  machine_word[7:0]          = b;
            REL_MACH_HI:  machine_word[15:8]         = b;
            REL_OPT_LO:   optional_size[7:0]         = b;
            REL_OPT_HI:   optional_size[15:8]        = b;
            REL_CHAR_LO:  characteristics_word[7:0]  = b;
            REL_CHAR_HI:  characteristics_word[15:8] = b;
            REL_MAGIC_LO: magic_word[7:0]            = b;
            REL_MAGIC_HI: magic_word[15:8]           = b;
            REL_ENTRY_0:  entry_word[7:0]            = b;
            REL_ENTRY_1:  entry_word[15:8]           = b;
            REL_ENTRY_2:  entry_word[23:16]          = b;
            REL_ENTRY_3:  entry_word[31:24]          = b;
            default: ;
         endcase
      endfunction

      function void take_byte(req_payload_type p);
         longint unsigned image_len;
         longint unsigned offs;
         bit              ok;
         rsp_payload_type v;
         if (byte_count != COUNT_MAX) begin
            parse_byte(byte_count, p.data_byte);
            byte_count++;
         end
         if (!p.last_byte) return;
         image_len = byte_count;
         offs      = header_offset;
         ok = !failed && image_len >= MIN_HEADER_OFFSET &&
              image_len >= offs + REQUIRED_AFTER_HEADER &&
              optional_size >= MIN_OPTIONAL_SIZE &&
              image_len - offs >= SIG_AND_FILE_HEADER + optional_size;
         v = '0;
         if (ok) begin
            v.valid_res      = 1'b1;
            v.machine        = machine_word;
            v.optional_magic = magic_word;
            v.entry_point    = entry_word;
            v.is_dll         = characteristics_word[DLL_BIT];
            valid_images++;
         end
         verdicts.push_back(v);
         images++;
         rearm();
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("verdict %0d %s: expected %h, got %h", checked, field, want, got);
      endfunction

      function void check_verdict(rsp_payload_type got);
         rsp_payload_type want;
         if (verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("verdict with none pending: %p", got);
            return;
         end
         want = verdicts.pop_front();
         checked++;
         if (got.valid_res !== want.valid_res) report("valid_res", want.valid_res, got.valid_res);
         if (got.machine !== want.machine) report("machine", want.machine, got.machine);
         if (got.optional_magic !== want.optional_magic)
            report("optional_magic", want.optional_magic, got.optional_magic);
         if (got.entry_point !== want.entry_point)
            report("entry_point", want.entry_point, got.entry_point);
         if (got.is_dll !== want.is_dll) report("is_dll", want.is_dll, got.is_dll);
      endfunction

      function int unsigned pending();
         return verdicts.size();
      endfunction

      function void close();
         if (verdicts.size() != 0) begin
            mismatches += verdicts.size();
            $display("%0d verdicts never arrived", verdicts.size());
         end
      endfunction

   endclass

endpackage

[bench/pe_header_identity_parser_top_test.sv]
// ----------------------------------------------------------------------------
// pe_header_identity_parser_top_test
// self-checking bench for the executable header identity parser
// ----------------------------------------------------------------------------
// streams directed and random images through the byte channel, some well
// formed, some with broken marks, offsets, signatures, sizes or lengths, and
// some pure noise; both channels idle at random, the receiver once holds off
// long enough to back up the input, and every verdict is scored on arrival
// ----------------------------------------------------------------------------
module pe_header_identity_parser_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   import pehip_pkg::*;
   import pehip_bench_pkg::*;

   localparam int unsigned ITEM_GOAL   = 1700;
   localparam int unsigned LONG_HOLD   = 400;
   localparam int unsigned IDLE_LIMIT  = 5000;

   typedef enum int unsigned {
      FAULT_MARK_M,
      FAULT_MARK_Z,
      FAULT_OFFSET_LOW,
      FAULT_OFFSET_HIGH,
      FAULT_SIGNATURE,
      FAULT_OPTIONAL_SIZE,
      FAULT_LENGTH
   } image_fault_type;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;

   pe_identity_scoreboard identity_board;

   logic [7:0]  image[$];
   logic [31:0] hdr_offset;
   logic [15:0] hdr_optional;
   bit          hold_request = 1'b0;
   int unsigned idle_cycles  = 0;
   int unsigned bytes_sent   = 0;
   int unsigned images_sent  = 0;

   pe_header_identity_parser_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic void put_le(longint unsigned pos, int unsigned n, logic [31:0] value);
      for (int unsigned i = 0; i < n; i++)
         if (pos + i < image.size()) image[pos + i] = value[8*i +: 8];
   endfunction

   function automatic void build_image(int unsigned len, logic [31:0] offs, logic [15:0] opt,
                                       logic [15:0] mach, logic [15:0] chars,
                                       logic [15:0] magic, logic [31:0] entry);
      longint unsigned base;
      base = offs;
      image.delete();
      repeat (len) image.push_back(8'($urandom));
      put_le(MZ_POS_M, 1, CHAR_M);
      put_le(MZ_POS_Z, 1, CHAR_Z);
      put_le(OFFSET_FIELD_POS, 4, offs);
      put_le(base + REL_SIG_P, 1, CHAR_P);
      put_le(base + REL_SIG_E, 1, CHAR_E);
      put_le(base + REL_SIG_Z0, 2, 32'h0);
      put_le(base + REL_MACH_LO, 2, mach);
      put_le(base + REL_OPT_LO, 2, opt);
      put_le(base + REL_CHAR_LO, 2, chars);
      put_le(base + REL_MAGIC_LO, 2, magic);
      put_le(base + REL_ENTRY_0, 4, entry);
   endfunction

   function automatic void make_header_image();
      int unsigned need;
      int unsigned len;
      logic [15:0] magic;
      hdr_offset   = ($urandom_range(0, 9) == 0) ? $urandom_range(97, 400) : $urandom_range(64, 96);
      hdr_optional = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(49, 224)
                                                      : $urandom_range(20, 48));
      need = 32'(hdr_offset + SIG_AND_FILE_HEADER + hdr_optional);
      if (need < hdr_offset + REQUIRED_AFTER_HEADER)
         need = 32'(hdr_offset + REQUIRED_AFTER_HEADER);
      len = ($urandom_range(0, 3) == 0) ? need : need + $urandom_range(1, 8);
      case ($urandom_range(0, 3))
         0:       magic = 16'h010b;
         1:       magic = 16'h020b;
         default: magic = 16'($urandom);
      endcase
      build_image(len, hdr_offset, hdr_optional, 16'($urandom), 16'($urandom), magic, $urandom);
   endfunction

   function automatic void break_image();
      image_fault_type fault;
      int unsigned     keep;
      fault = image_fault_type'($urandom_range(0, 6));
      case (fault)
         FAULT_MARK_M: image[MZ_POS_M] = CHAR_M ^ 8'($urandom_range(1, 255));
         FAULT_MARK_Z: image[MZ_POS_Z] = CHAR_Z ^ 8'($urandom_range(1, 255));
         FAULT_OFFSET_LOW: put_le(OFFSET_FIELD_POS, 4, $urandom_range(0, 63));
         FAULT_OFFSET_HIGH:
            put_le(OFFSET_FIELD_POS, 4, ($urandom_range(0, 1) == 0) ?
                   MAX_HEADER_OFFSET + 1 + $urandom_range(0, 255) : ($urandom | 32'h8000_0000));
         FAULT_SIGNATURE:
            image[hdr_offset + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
         FAULT_OPTIONAL_SIZE:
            put_le(longint'(hdr_offset) + REL_OPT_LO, 2, $urandom_range(0, 19));
         FAULT_LENGTH: begin
            keep = $urandom_range(1, image.size() - 1);
            while (image.size() > keep) void'(image.pop_back());
         end
         default: ;
      endcase
   endfunction

   function automatic void noise_image();
      int unsigned len;
      len = $urandom_range(1, 80);
      image.delete();
      repeat (len) image.push_back(8'($urandom));
      if ($urandom_range(0, 1) == 0) begin
         image[MZ_POS_M] = CHAR_M;
         if (len > 1) image[MZ_POS_Z] = CHAR_Z;
      end
   endfunction

   task automatic drive_byte(req_payload_type p, bit burst);
      int unsigned gap;
      gap = burst ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_image(bit burst);
      req_payload_type p;
      foreach (image[i]) begin
         p.data_byte = image[i];
         p.last_byte = (i == image.size() - 1);
         drive_byte(p, burst);
      end
      images_sent++;
      bytes_sent += image.size();
   endtask

   task automatic directed_image(int unsigned len, logic [31:0] offs, logic [15:0] opt,
                                 logic [15:0] mach, logic [15:0] chars,
                                 logic [15:0] magic, logic [31:0] entry);
      build_image(len, offs, opt, mach, chars, magic, entry);
      send_image(1'b0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (identity_board.pending() != 0) @(posedge clock);
   endtask

   // tiny images back to back while the receiver holds off
   task automatic press_receiver();
      hold_request = 1'b1;
      repeat (16) begin
         image.delete();
         repeat ($urandom_range(1, 3)) image.push_back(8'($urandom));
         send_image(1'b1);
      end
      wait_drained();
   endtask

   initial begin
      bit          level;
      int unsigned left;
      int unsigned r;
      level = 1'b0;
      left  = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            level        = 1'b1;
            left         = LONG_HOLD;
         end else if (left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               level = 1'b0;
               left  = $urandom_range(1, 20);
            end else if (r < 80) begin
               level = 1'b1;
               left  = $urandom_range(1, 3);
            end else if (r < 92) begin
               level = 1'b1;
               left  = $urandom_range(4, 12);
            end else if (r < 97) begin
               level = 1'b1;
               left  = $urandom_range(20, 60);
            end else begin
               level = 1'b0;
               left  = $urandom_range(100, 300);
            end
         end
         rsp_stall <= level;
         left--;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) identity_board.take_byte(req_payload);
         if (rsp_valid && !rsp_stall) identity_board.check_verdict(rsp_payload);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("no transfer for %0d cycles", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int unsigned kind;
      bit          burst;
      bit          pressed;
      pressed        = 1'b0;
      identity_board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      directed_image(1, 64, 20, 16'h0, 16'h0, 16'h0, 32'h0);
      directed_image(2, 64, 20, 16'h0, 16'h0, 16'h0, 32'h0);
      directed_image(63, 64, 20, 16'h0, 16'h0, 16'h0, 32'h0);
      directed_image(64, 64, 20, 16'h0, 16'h0, 16'h0, 32'h0);
      directed_image(108, 64, 20, 16'h0, 16'h0, 16'h0, 32'h0);
      directed_image(108, 64, 20, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      directed_image(107, 64, 20, 16'h014c, 16'h0102, 16'h010b, 32'h0000_1000);
      directed_image(134, 70, 40, 16'h8664, 16'h2022, 16'h020b, $urandom);
      directed_image(133, 70, 40, 16'h8664, 16'h2022, 16'h020b, $urandom);
      directed_image(108, 64, 19, 16'h014c, 16'h0002, 16'h010b, $urandom);
      directed_image(108, 64, 16'hFFFF, 16'h014c, 16'h0002, 16'h010b, $urandom);
      directed_image(64, 63, 20, 16'h0, 16'h0, 16'h0, 32'h0);
      directed_image(64, 0, 20, 16'h0, 16'h0, 16'h0, 32'h0);
      directed_image(64, MAX_HEADER_OFFSET + 1, 20, 16'h0, 16'h0, 16'h0, 32'h0);
      directed_image(64, 32'hFFFF_FFFF, 20, 16'h0, 16'h0, 16'h0, 32'h0);
      build_image(108, 64, 20, 16'h014c, 16'h2000, 16'h010b, $urandom);
      image[MZ_POS_M] = CHAR_M ^ 8'h80;
      send_image(1'b0);
      build_image(108, 64, 20, 16'h014c, 16'h2000, 16'h010b, $urandom);
      image[MZ_POS_Z] = CHAR_Z ^ 8'h01;
      send_image(1'b0);
      build_image(108, 64, 20, 16'h014c, 16'h2000, 16'h010b, $urandom);
      image[64 + REL_SIG_Z1] = 8'h01;
      send_image(1'b0);
      wait_drained();

      while (bytes_sent < ITEM_GOAL) begin
         if (!pressed && bytes_sent >= ITEM_GOAL / 2) begin
            press_receiver();
            pressed = 1'b1;
         end
         burst = ($urandom_range(0, 3) == 0);
         kind  = $urandom_range(0, 99);
         if (kind < 55) begin
            make_header_image();
         end else if (kind < 82) begin
            make_header_image();
            break_image();
         end else begin
            noise_image();
         end
         send_image(burst);
         if ($urandom_range(0, 15) == 0) wait_drained();
      end
      wait_drained();
      repeat (6) @(posedge clock);

      identity_board.close();
      $display("covered %0d images, %0d of them valid, over %0d bytes", identity_board.images,
               identity_board.valid_images, bytes_sent);
      $display("with bad marks, offsets, signatures, sizes, short lengths and a %0d-cycle hold",
               LONG_HOLD);
      if (identity_board.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/pehip_pkg.sv
hw/rtl/pehip_core.sv
hw/rtl/pe_header_identity_parser_top.sv
hw/rtl/pehip_checker.sv
bench/pehip_bench_pkg.sv
bench/pe_header_identity_parser_top_test.sv
